/* rtl/gamma_pwm_duty_calculator_top_defines.svh */
// Assertion macros for the gamma PWM duty calculator.
`ifndef GAMMA_PWM_DUTY_CALCULATOR_TOP_DEFINES_SVH
`define GAMMA_PWM_DUTY_CALCULATOR_TOP_DEFINES_SVH

// plain property, checked outside reset
`define GPD_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define GPD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/gpd_pkg.sv */
// Shared types, constants and elaboration-time functions of the gamma PWM duty calculator.
package gpd_pkg;

   localparam logic [2:0] CSR_BRIGHTNESS_RANGE = 3'd0;
   localparam logic [2:0] CSR_BOUND_LEVEL      = 3'd1;
   localparam logic [2:0] CSR_BOUND_RANGE      = 3'd2;
   localparam logic [2:0] CSR_GAMMA_VALUE      = 3'd3;
   localparam logic [2:0] CSR_TIMER_PERIOD     = 3'd4;
   localparam logic [2:0] CSR_ACTIVE_HIGH      = 3'd5;

   localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

   typedef struct packed {
      logic       valid;
      logic [1:0] chan;
   } pipe_type;

   typedef struct packed {
      logic [15:0] bright_scale;
      logic [15:0] bound_level;
      logic [15:0] bound_scale;
      logic [15:0] gamma_value;
      logic [15:0] timer_period;
      logic        active_high;
   } cfg_type;

   typedef enum logic [1:0] {
      CLS_POW,
      CLS_ONE,
      CLS_ZERO
   } cls_type;

   function automatic logic [63:0] gpd_isqrt(input logic [63:0] arg);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x    = arg;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-i) in Q1.31, built by repeated integer square roots
   function automatic logic [31:0] gpd_root(input int idx);
      logic [63:0] c;
      c = gpd_isqrt(64'd1 << 61);
      for (int k = 2; k <= idx; k++) begin
         c = gpd_isqrt(c << 31);
      end
      return c[31:0];
   endfunction

endpackage

/* rtl/gpd_div.sv */
// Pipelined restoring divider forming the rounded Q1.24 ratio.
module gpd_div import gpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  pipe_type    in_pipe,
   input  logic [31:0] in_prod,
   input  logic [31:0] in_den,
   input  logic        in_zero,
   output pipe_type    out_pipe,
   output logic [24:0] out_ratio
);
   localparam int QW = 25;

   pipe_type          pipe_ff [0:QW];
   logic [31:0]       rem_ff  [0:QW];
   logic [QW-1:0]     low_ff  [0:QW];
   logic [QW-1:0]     q_ff    [0:QW];
   logic [31:0]       den_ff  [0:QW];
   logic              zero_ff [0:QW];
   logic [56:0]       num_in;

   assign num_in = {1'b0, in_prod, 24'd0} + {26'd0, in_den[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff[0] <= '0;
      end else begin
         pipe_ff[0] <= in_pipe;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num_in[56:25];
      low_ff[0]  <= num_in[24:0];
      q_ff[0]    <= '0;
      den_ff[0]  <= in_den;
      zero_ff[0] <= in_zero;
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [32:0] trial_in;
      logic [32:0] diff_in;
      logic        ge_in;
      assign trial_in = {rem_ff[k], low_ff[k][QW-1]};
      assign diff_in  = trial_in - {1'b0, den_ff[k]};
      assign ge_in    = trial_in >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[k+1] <= '0;
         end else begin
            pipe_ff[k+1] <= pipe_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge_in ? diff_in[31:0] : trial_in[31:0];
         low_ff[k+1]  <= {low_ff[k][QW-2:0], 1'b0};
         q_ff[k+1]    <= {q_ff[k][QW-2:0], ge_in};
         den_ff[k+1]  <= den_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end
   end

   assign out_pipe  = pipe_ff[QW];
   assign out_ratio = zero_ff[QW] ? '0 : q_ff[QW];
endmodule

/* rtl/gpd_log.sv */
// Pipelined log2 by repeated squaring; yields -log2(ratio) in Q.30.
module gpd_log import gpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  pipe_type    in_pipe,
   input  logic [24:0] in_ratio,
   input  logic        gamma_zero,
   output pipe_type    out_pipe,
   output cls_type     out_cls,
   output logic [34:0] out_lm
);
   localparam int NSQ = 30;

   pipe_type    p0_pipe_ff;
   cls_type     p0_cls_ff;
   logic [23:0] p0_r_ff;
   logic [4:0]  p0_msb_ff;
   cls_type     cls_in;
   logic [4:0]  msb_in;

   pipe_type    pipe_ff [0:NSQ];
   cls_type     cls_ff  [0:NSQ];
   logic [31:0] x_ff    [0:NSQ];
   logic [29:0] frac_ff [0:NSQ];
   logic [4:0]  e_ff    [0:NSQ];

   pipe_type    lm_pipe_ff;
   cls_type     lm_cls_ff;
   logic [34:0] lm_ff;

   always_comb begin
      msb_in = 5'd0;
      for (int j = 0; j < 24; j++) begin
         if (in_ratio[j]) msb_in = 5'(j);
      end
      priority if (gamma_zero)        cls_in = CLS_ONE;
      else if (in_ratio == '0)        cls_in = CLS_ZERO;
      else if (in_ratio[24])          cls_in = CLS_ONE;
      else                            cls_in = CLS_POW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_pipe_ff <= '0;
         pipe_ff[0] <= '0;
         lm_pipe_ff <= '0;
      end else begin
         p0_pipe_ff <= in_pipe;
         pipe_ff[0] <= p0_pipe_ff;
         lm_pipe_ff <= pipe_ff[NSQ];
      end
   end

   always_ff @(posedge clock) begin
      p0_cls_ff  <= cls_in;
      p0_r_ff    <= in_ratio[23:0];
      p0_msb_ff  <= msb_in;
      cls_ff[0]  <= p0_cls_ff;
      x_ff[0]    <= {8'd0, p0_r_ff} << (5'd31 - p0_msb_ff);
      frac_ff[0] <= '0;
      e_ff[0]    <= 5'd24 - p0_msb_ff;
      lm_cls_ff  <= cls_ff[NSQ];
      lm_ff      <= {e_ff[NSQ], 30'd0} - {5'd0, frac_ff[NSQ]};
   end

   for (genvar k = 0; k < NSQ; k++) begin : g_sq
      logic [63:0] sq_in;
      assign sq_in = {32'd0, x_ff[k]} * {32'd0, x_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[k+1] <= '0;
         end else begin
            pipe_ff[k+1] <= pipe_ff[k];
         end
      end

      // square lands in [1,4): renormalize and take one fraction bit
      always_ff @(posedge clock) begin
         x_ff[k+1]    <= sq_in[63] ? sq_in[63:32] : sq_in[62:31];
         frac_ff[k+1] <= {frac_ff[k][28:0], sq_in[63]};
         e_ff[k+1]    <= e_ff[k];
         cls_ff[k+1]  <= cls_ff[k];
      end
   end

   assign out_pipe = lm_pipe_ff;
   assign out_cls  = lm_cls_ff;
   assign out_lm   = lm_ff;
endmodule

/* rtl/gpd_exp.sv */
// Gamma scaling, pipelined exp2 by root products, period scaling and polarity.
module gpd_exp import gpd_pkg::*; #(
   parameter int GAMMA_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  pipe_type    in_pipe,
   input  cls_type     in_cls,
   input  logic [34:0] in_lm,
   input  logic [15:0] gamma_value,
   input  logic [15:0] full,
   input  logic        active_high,
   output pipe_type    out_pipe,
   output logic [15:0] out_value
);
   localparam int NR = 30;

   pipe_type    e0_pipe_ff;
   cls_type     e0_cls_ff;
   logic [51:0] gp_ff;
   logic [51:0] mq_w;

   pipe_type    pipe_ff [0:NR];
   cls_type     cls_ff  [0:NR];
   logic [29:0] f_ff    [0:NR];
   logic [4:0]  n_ff    [0:NR];
   logic        big_ff  [0:NR];
   logic [31:0] v_ff    [0:NR];

   pipe_type    sh_pipe_ff;
   logic [31:0] vf_ff;
   pipe_type    sc_pipe_ff;
   logic [16:0] val_ff;
   logic [47:0] sc_w;
   pipe_type    out_pipe_ff;
   logic [15:0] out_ff;

   assign mq_w = gp_ff >> GAMMA_FRAC_BITS;
   assign sc_w = {16'd0, vf_ff} * {32'd0, full} + (48'd1 << 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_pipe_ff  <= '0;
         pipe_ff[0]  <= '0;
         sh_pipe_ff  <= '0;
         sc_pipe_ff  <= '0;
         out_pipe_ff <= '0;
      end else begin
         e0_pipe_ff  <= in_pipe;
         pipe_ff[0]  <= e0_pipe_ff;
         sh_pipe_ff  <= pipe_ff[NR];
         sc_pipe_ff  <= sh_pipe_ff;
         out_pipe_ff <= sc_pipe_ff;
      end
   end

   always_ff @(posedge clock) begin
      e0_cls_ff <= in_cls;
      gp_ff     <= {36'd0, gamma_value} * {17'd0, in_lm}
                   + (52'd1 << (GAMMA_FRAC_BITS - 1));
      cls_ff[0] <= e0_cls_ff;
      f_ff[0]   <= mq_w[29:0];
      n_ff[0]   <= mq_w[34:30];
      big_ff[0] <= mq_w[51:30] >= 22'd17;
      v_ff[0]   <= 32'h8000_0000;
      priority if (cls_ff[NR] == CLS_ONE)                vf_ff <= 32'h8000_0000;
      else if (cls_ff[NR] == CLS_ZERO || big_ff[NR])     vf_ff <= '0;
      else                                               vf_ff <= v_ff[NR] >> n_ff[NR];
      val_ff <= sc_w[47:31];
      if (val_ff > {1'b0, full}) begin
         out_ff <= active_high ? full : 16'd0;
      end else begin
         out_ff <= active_high ? val_ff[15:0] : full - val_ff[15:0];
      end
   end

   for (genvar i = 1; i <= NR; i++) begin : g_root
      localparam logic [31:0] RootC = gpd_root(i);
      logic [63:0] pr_in;
      assign pr_in = {32'd0, v_ff[i-1]} * {32'd0, RootC};

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[i] <= '0;
         end else begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         v_ff[i]   <= f_ff[i-1][NR-i] ? pr_in[62:31] : v_ff[i-1];
         f_ff[i]   <= f_ff[i-1];
         n_ff[i]   <= n_ff[i-1];
         big_ff[i] <= big_ff[i-1];
         cls_ff[i] <= cls_ff[i-1];
      end
   end

   assign out_pipe  = out_pipe_ff;
   assign out_value = out_ff;
endmodule

/* rtl/gamma_pwm_duty_calculator_top.sv */
// Top level of the gamma PWM duty calculator: registers, clamp stages and pipeline.
//
//  channel   ports                                         handshake
//  request   req_brightness_request, req_channel_select    start & !busy
//  result    rsp_compare_value, rsp_channel_out            rsp_valid, one cycle
//  config    csr_index, csr_data                           csr_valid & csr_ready
//
// One item enters per cycle while busy is low.
// The pipeline holds the 25-stage quotient divider, 30 squaring stages of the
// log2 and 30 root-product stages of the exp2, plus clamp and scaling stages.
// Synchronous reset clears the valid bits; busy is high during reset and in the cycle after it is released.
// The receiver cannot stall, so the pipeline never holds.
`include "gamma_pwm_duty_calculator_top_defines.svh"
module gamma_pwm_duty_calculator_top import gpd_pkg::*; #(
   parameter int GAMMA_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_brightness_request,
   input  logic [1:0]  req_channel_select,
   output logic        rsp_valid,
   output logic [15:0] rsp_compare_value,
   output logic [1:0]  rsp_channel_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   cfg_type     cfg_ff;
   logic        busy_ff;
   logic        accept_w;
   logic [15:0] full_w;
   logic        gamma_zero_w;
   logic        unit_hi_w;
   logic        unit_lo_w;

   pipe_type    t1_pipe_ff;
   logic [15:0] b_ff;
   logic [15:0] d_ff;
   pipe_type    t2_pipe_ff;
   logic [31:0] prod_ff;
   logic [31:0] den_ff;
   logic        zero_ff;

   pipe_type    div_pipe;
   logic [24:0] div_ratio;
   pipe_type    log_pipe;
   cls_type     log_cls;
   logic [34:0] log_lm;
   pipe_type    exp_pipe;

   assign accept_w  = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   // a period of all ones is treated as one less
   assign full_w = (cfg_ff.timer_period == PERIOD_MAX) ? PERIOD_MAX
                   : cfg_ff.timer_period + 16'd1;
   assign gamma_zero_w = (cfg_ff.gamma_value == 16'd0);
   assign unit_hi_w    = rsp_valid && gamma_zero_w && cfg_ff.active_high;
   assign unit_lo_w    = rsp_valid && gamma_zero_w && !cfg_ff.active_high;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff             <= 1'b1;
         cfg_ff.bright_scale <= 16'd1000;
         cfg_ff.bound_level  <= 16'd1000;
         cfg_ff.bound_scale  <= 16'd1000;
         cfg_ff.gamma_value  <= 16'd9011;
         cfg_ff.timer_period <= 16'd65534;
         cfg_ff.active_high  <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BRIGHTNESS_RANGE: cfg_ff.bright_scale <= csr_data;
               CSR_BOUND_LEVEL:      cfg_ff.bound_level  <= csr_data;
               CSR_BOUND_RANGE:      cfg_ff.bound_scale  <= csr_data;
               CSR_GAMMA_VALUE:      cfg_ff.gamma_value  <= csr_data;
               CSR_TIMER_PERIOD:     cfg_ff.timer_period <= csr_data;
               CSR_ACTIVE_HIGH:      cfg_ff.active_high  <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_pipe_ff <= '0;
         t2_pipe_ff <= '0;
      end else begin
         t1_pipe_ff <= '{valid: accept_w, chan: req_channel_select};
         t2_pipe_ff <= t1_pipe_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ff <= (req_brightness_request < cfg_ff.bright_scale)
              ? req_brightness_request : cfg_ff.bright_scale;
      d_ff <= (cfg_ff.bound_level < cfg_ff.bound_scale)
              ? cfg_ff.bound_level : cfg_ff.bound_scale;
      prod_ff <= {16'd0, b_ff} * {16'd0, d_ff};
      den_ff  <= {16'd0, cfg_ff.bright_scale} * {16'd0, cfg_ff.bound_scale};
      zero_ff <= (b_ff == 16'd0) || (d_ff == 16'd0);
   end

   gpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_pipe   (t2_pipe_ff),
      .in_prod   (prod_ff),
      .in_den    (den_ff),
      .in_zero   (zero_ff),
      .out_pipe  (div_pipe),
      .out_ratio (div_ratio)
   );

   gpd_log u_log (
      .clock      (clock),
      .reset      (reset),
      .in_pipe    (div_pipe),
      .in_ratio   (div_ratio),
      .gamma_zero (gamma_zero_w),
      .out_pipe   (log_pipe),
      .out_cls    (log_cls),
      .out_lm     (log_lm)
   );

   gpd_exp #(
      .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
   ) u_exp (
      .clock       (clock),
      .reset       (reset),
      .in_pipe     (log_pipe),
      .in_cls      (log_cls),
      .in_lm       (log_lm),
      .gamma_value (cfg_ff.gamma_value),
      .full        (full_w),
      .active_high (cfg_ff.active_high),
      .out_pipe    (exp_pipe),
      .out_value   (rsp_compare_value)
   );

   assign rsp_valid       = exp_pipe.valid;
   assign rsp_channel_out = exp_pipe.chan;

   `GPD_ASSERT_IMPL(a_cmp_in_period, clock, reset, rsp_valid, rsp_compare_value <= full_w, "compare value beyond period")
   `GPD_ASSERT_IMPL(a_gamma_zero_hi, clock, reset, unit_hi_w, rsp_compare_value == full_w, "unit power not full")
   `GPD_ASSERT_IMPL(a_gamma_zero_lo, clock, reset, unit_lo_w, rsp_compare_value == 16'd0, "unit power not zero")
   `GPD_ASSERT_ON(a_ready_high, clock, reset, csr_ready, "config port not ready")
endmodule
